>>> hdl/assert_macros.svh
// Shared assertion forms for the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hdl/tdpc_pkg.sv
package tdpc_pkg;

  localparam int CALIB_POINTS = 4;
  localparam int DUTY_W = 16;
  localparam int FLOW_W = 32;
  localparam int NUM_W = 48;
  localparam int CFG_W = 48;
  localparam int IDX_W = 3;

  localparam logic [2:0] FUNC_ON = 3'd0;
  localparam logic [2:0] FUNC_OFF = 3'd1;
  localparam logic [2:0] FUNC_SET = 3'd2;
  localparam logic [2:0] FUNC_SPEED = 3'd3;
  localparam logic [2:0] FUNC_TICK = 3'd4;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_WORKING = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  localparam logic [IDX_W-1:0] REG_MIN_DUTY = 3'd0;
  localparam logic [IDX_W-1:0] REG_MAX_DUTY = 3'd1;
  localparam logic [IDX_W-1:0] REG_POINT_COUNT = 3'd2;
  localparam logic [IDX_W-1:0] REG_CALIB_0 = 3'd3;
  localparam logic [IDX_W-1:0] REG_CALIB_1 = 3'd4;
  localparam logic [IDX_W-1:0] REG_CALIB_2 = 3'd5;
  localparam logic [IDX_W-1:0] REG_CALIB_3 = 3'd6;

  localparam logic [9:0] MS_PER_S = 10'd1000;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_MUL     = 6'b000010,
    S_DIV_MAG = 6'b000100,
    S_DOSE    = 6'b001000,
    S_DIV_MS  = 6'b010000,
    S_OUT     = 6'b100000
  } state_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [FLOW_W-1:0] den;
  } div_req_t;

endpackage

>>> hdl/tdpc_div.sv
module tdpc_div (
  input  logic              clk,
  input  logic              rst,
  input  tdpc_pkg::div_req_t req,
  output logic              done,
  output logic [tdpc_pkg::NUM_W-1:0] quo
);
  import tdpc_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [FLOW_W-1:0] rem;
  logic [FLOW_W-1:0] den;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [FLOW_W:0]   trial;
  logic              fits;

  assign trial = {rem, quo[NUM_W-1]};
  assign fits = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // One quotient bit per cycle, restoring.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      den <= req.den;
      quo <= req.num;
    end else if (busy) begin
      rem <= fits ? FLOW_W'(trial - {1'b0, den}) : trial[FLOW_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

endmodule

>>> hdl/timed_dosing_pump_controller_core.sv
// Dosing pump controller. Each request (on, off, dose, speed, 1 ms tick) gives one
// result; a new request is taken only after the previous result has been loaded
// into the output register. On, off, speed, tick and rejected commands go from
// acceptance straight to the output state. A dose passes the dose state, where
// zero flow is rejected; one shared restoring divider then forms the dose time
// in ms, after first forming the interpolated flow when the duty falls inside a
// calibration segment. A stalled result holds the block for as long as the
// stall lasts. Write configuration while idle.
module timed_dosing_pump_controller_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [tdpc_pkg::IDX_W-1:0] cfg_index,
  input  logic [tdpc_pkg::CFG_W-1:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  func,
  input  logic [15:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [15:0] duty,
  output logic        running,
  output logic        dose_finished
);
  import tdpc_pkg::*;

  logic [DUTY_W-1:0] min_duty, max_duty;
  logic [2:0]        point_count;
  logic [CFG_W-1:0]  calib_point [CALIB_POINTS];

  logic [DUTY_W-1:0] speed_setting;
  logic              pump_on, dose_active;
  logic [31:0]       remaining_ms;

  state_t            state;
  logic [1:0]        res_status;
  logic              res_fin;
  logic [DUTY_W-1:0] value_r;
  logic [FLOW_W-1:0] y0_r, dy_r, flow_r;
  logic [DUTY_W-1:0] dd_r, span_r;
  logic              neg_r;

  div_req_t          div_req;
  logic              div_done;
  logic [NUM_W-1:0]  div_quo;

  logic              accept;
  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;

  // Config writes; indexes past the table are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_duty <= '0;
      max_duty <= '1;
      point_count <= 3'd1;
      for (int k = 0; k < CALIB_POINTS; k++) calib_point[k] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_DUTY:    min_duty <= cfg_data[DUTY_W-1:0];
        REG_MAX_DUTY:    max_duty <= cfg_data[DUTY_W-1:0];
        REG_POINT_COUNT: point_count <= cfg_data[2:0];
        REG_CALIB_0:     calib_point[0] <= cfg_data;
        REG_CALIB_1:     calib_point[1] <= cfg_data;
        REG_CALIB_2:     calib_point[2] <= cfg_data;
        REG_CALIB_3:     calib_point[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Segment lookup at the stored duty.
  logic [DUTY_W-1:0] pd [CALIB_POINTS];
  logic [FLOW_W-1:0] pf [CALIB_POINTS];
  logic [2:0]        n_pts;
  logic [1:0]        last;
  logic              direct, seg_found;
  logic [FLOW_W-1:0] direct_flow;
  logic [1:0]        seg;

  always_comb begin
    for (int k = 0; k < CALIB_POINTS; k++) begin
      pd[k] = calib_point[k][47:32];
      pf[k] = calib_point[k][31:0];
    end
    if (point_count == 3'd0) n_pts = 3'd1;
    else if (point_count > 3'(CALIB_POINTS)) n_pts = 3'(CALIB_POINTS);
    else n_pts = point_count;
    last = 2'(n_pts - 3'd1);
    seg_found = 1'b0;
    seg = '0;
    for (int i = CALIB_POINTS - 2; i >= 0; i--) begin
      if ((3'(i + 1) < n_pts) && speed_setting >= pd[i] && speed_setting <= pd[i+1]) begin
        seg_found = 1'b1;
        seg = 2'(i);
      end
    end
    direct = 1'b1;
    if (speed_setting <= pd[0]) direct_flow = pf[0];
    else if (speed_setting >= pd[last]) direct_flow = pf[last];
    else if (!seg_found) direct_flow = '0;
    else if (pd[2'(seg + 2'd1)] == pd[seg]) direct_flow = pf[seg];
    else begin
      direct = 1'b0;
      direct_flow = pf[seg];
    end
  end

  logic [FLOW_W-1:0] y1_sel;
  assign y1_sel = pf[2'(seg + 2'd1)];

  logic [NUM_W-1:0] ms_num;
  assign ms_num = NUM_W'({26'(value_r) * 26'(MS_PER_S), 16'b0});

  always_comb begin
    div_req.start = 1'b0;
    div_req.num = ms_num;
    div_req.den = flow_r;
    if (state == S_MUL) begin
      div_req.start = 1'b1;
      div_req.num = NUM_W'(dy_r) * NUM_W'(dd_r);
      div_req.den = FLOW_W'(span_r);
    end else if (state == S_DOSE && flow_r != '0) begin
      div_req.start = 1'b1;
    end
  end

  tdpc_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quo  (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      speed_setting <= '0;
      pump_on <= 1'b0;
      dose_active <= 1'b0;
      remaining_ms <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_OUT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            value_r <= value;
            res_fin <= (func == FUNC_TICK) && dose_active && (remaining_ms <= 32'd1);
            case (func)
              FUNC_ON: begin
                // an already running pump stays on
                res_status <= pump_on ? ST_ERROR : ST_DONE;
                pump_on <= 1'b1;
                state <= S_OUT;
              end
              FUNC_OFF: begin
                res_status <= ST_DONE;
                pump_on <= 1'b0;
                dose_active <= 1'b0;
                remaining_ms <= '0;
                state <= S_OUT;
              end
              FUNC_SET: begin
                if (pump_on) begin
                  res_status <= ST_ERROR;
                  state <= S_OUT;
                end else begin
                  y0_r <= direct_flow;
                  flow_r <= direct_flow;
                  neg_r <= y1_sel < direct_flow;
                  dy_r <= (y1_sel < direct_flow) ? direct_flow - y1_sel
                                                 : y1_sel - direct_flow;
                  dd_r <= speed_setting - pd[seg];
                  span_r <= pd[2'(seg + 2'd1)] - pd[seg];
                  state <= direct ? S_DOSE : S_MUL;
                end
              end
              FUNC_SPEED: begin
                res_status <= ST_DONE;
                state <= S_OUT;
                if (value < min_duty) speed_setting <= '0;
                else if (value > max_duty) speed_setting <= max_duty;
                else speed_setting <= value;
              end
              FUNC_TICK: begin
                res_status <= ST_DONE;
                state <= S_OUT;
                if (dose_active) begin
                  if (remaining_ms <= 32'd1) begin
                    remaining_ms <= '0;
                    dose_active <= 1'b0;
                    pump_on <= 1'b0;
                  end else begin
                    remaining_ms <= remaining_ms - 32'd1;
                  end
                end
              end
              default: begin
                res_status <= ST_ERROR;
                state <= S_OUT;
              end
            endcase
          end
        end
        S_MUL: state <= S_DIV_MAG;
        S_DIV_MAG: begin
          if (div_done) begin
            flow_r <= neg_r ? y0_r - div_quo[FLOW_W-1:0] : y0_r + div_quo[FLOW_W-1:0];
            state <= S_DOSE;
          end
        end
        S_DOSE: begin
          if (flow_r == '0) begin
            res_status <= ST_ERROR;
            state <= S_OUT;
          end else begin
            state <= S_DIV_MS;
          end
        end
        S_DIV_MS: begin
          if (div_done) begin
            remaining_ms <= (div_quo[NUM_W-1:32] != '0) ? '1 : div_quo[31:0];
            pump_on <= 1'b1;
            dose_active <= 1'b1;
            res_status <= ST_WORKING;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || !out_stall)) begin
      status <= res_status;
      duty <= pump_on ? speed_setting : '0;
      running <= pump_on;
      dose_finished <= res_fin;
    end
  end

endmodule

>>> hdl/tdpc_checker.sv
`include "assert_macros.svh"

module tdpc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic [15:0] duty,
  input logic        running,
  input logic        dose_finished
);
  import tdpc_pkg::*;

  `ASSERT_NEXT(a_busy_after_req, clk, rst, in_valid && !in_stall, in_stall)
  `ASSERT_IMPL(a_stopped_no_duty, clk, rst, out_valid && !running, duty == '0)
  `ASSERT_IMPL(a_finish_stops, clk, rst, out_valid && dose_finished,
               !running && status == ST_DONE)
  `ASSERT_IMPL(a_status_code, clk, rst, out_valid,
               status == ST_DONE || status == ST_WORKING || status == ST_ERROR)
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(status))

endmodule

bind timed_dosing_pump_controller_core tdpc_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .status        (status),
  .duty          (duty),
  .running       (running),
  .dose_finished (dose_finished)
);
